[hdl/ssg_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper step generator package
// Function codes, register indexes, reset values and the structs that are
// shared between the register file, the step core and the top level.
// ----------------------------------------------------------------------------
package ssg_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned TICK_W = 16;

	// Function codes of a command word.
	localparam logic [2:0] FUNC_TICK = 3'd0;
	localparam logic [2:0] FUNC_ABS  = 3'd1;
	localparam logic [2:0] FUNC_REL  = 3'd2;
	localparam logic [2:0] FUNC_LOAD = 3'd3;
	localparam logic [2:0] FUNC_HOME = 3'd4;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_STEP_INTERVAL = 2'd0;
	localparam logic [1:0] REG_BOUND_LOW     = 2'd1;
	localparam logic [1:0] REG_BOUND_HIGH    = 2'd2;

	localparam logic [TICK_W-1:0] MIN_INTERVAL      = 16'd40;
	localparam logic [TICK_W-1:0] RST_INTERVAL      = 16'd100;
	localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;
	localparam logic [DATA_W-1:0] RST_BOUND_LOW     = 32'h0000_0000;
	localparam logic [DATA_W-1:0] RST_BOUND_HIGH    = 32'h7FFF_FFFF;
	localparam int unsigned       HOME_INTERVAL_DEF = 100;

	typedef struct packed {
		logic [2:0]        func;
		logic [DATA_W-1:0] value;
		logic              home_toward_max;
		logic              limit_level;
	} cmd_t;

	typedef struct packed {
		logic              step_pulse;
		logic              dir_level;
		logic [DATA_W-1:0] position_now;
		logic              at_target;
		logic              homing_busy;
		logic              move_started;
	} res_t;

	typedef struct packed {
		logic [TICK_W-1:0] step_interval;
		logic [DATA_W-1:0] bound_low;
		logic [DATA_W-1:0] bound_high;
	} cfg_t;

endpackage

[hdl/ssg_regs.sv]
// ----------------------------------------------------------------------------
// Stepper step generator register file
// APB-style register block holding the step interval and the homing bounds.
// ----------------------------------------------------------------------------
module ssg_regs
	import ssg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [TICK_W-1:0] interval_q;
	logic [DATA_W-1:0] bound_low_q;
	logic [DATA_W-1:0] bound_high_q;
	logic              wr_en;
	logic [1:0]        reg_idx;
	logic [TICK_W-1:0] wr_interval;

	assign pready      = 1'b1;
	assign wr_en       = psel & penable & pwrite;
	assign reg_idx     = paddr[3:2];
	// Intervals below the minimum are clamped when written.
	assign wr_interval = (pwdata[TICK_W-1:0] < MIN_INTERVAL) ? MIN_INTERVAL
	                                                         : pwdata[TICK_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= RST_INTERVAL;
			bound_low_q  <= RST_BOUND_LOW;
			bound_high_q <= RST_BOUND_HIGH;
		end else if (wr_en) begin
			case (reg_idx)
				REG_STEP_INTERVAL: interval_q   <= wr_interval;
				REG_BOUND_LOW:     bound_low_q  <= pwdata;
				REG_BOUND_HIGH:    bound_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_STEP_INTERVAL: prdata = {{(DATA_W-TICK_W){1'b0}}, interval_q};
			REG_BOUND_LOW:     prdata = bound_low_q;
			REG_BOUND_HIGH:    prdata = bound_high_q;
			default:           prdata = '0;
		endcase
	end

	assign cfg.step_interval = interval_q;
	assign cfg.bound_low     = bound_low_q;
	assign cfg.bound_high    = bound_high_q;

endmodule

[hdl/ssg_core.sv]
// ----------------------------------------------------------------------------
// Stepper step generator core
// Holds the motion state and works out the result of one command word.
// ----------------------------------------------------------------------------
module ssg_core
	import ssg_pkg::*;
#(
	parameter int unsigned HOME_INTERVAL = HOME_INTERVAL_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  cmd_t cmd,
	input  cfg_t cfg,
	output res_t res
);

	localparam logic [TICK_W-1:0] HOME_IV = TICK_W'(HOME_INTERVAL);

	logic [DATA_W-1:0] pos_q,  pos_n;
	logic [DATA_W-1:0] tgt_q,  tgt_n;
	logic              dir_q,  dir_n;
	logic [TICK_W-1:0] ticks_q, ticks_n;
	logic              homing_q, homing_n;
	logic              to_max_q, to_max_n;
	logic [TICK_W-1:0] ticks_inc;
	logic [DATA_W-1:0] pos_stepped;
	logic              pulse;
	logic              started;

	assign ticks_inc   = (ticks_q != TICK_MAX) ? ticks_q + 16'd1 : ticks_q;
	assign pos_stepped = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;

	always_comb begin
		pos_n    = pos_q;
		tgt_n    = tgt_q;
		dir_n    = dir_q;
		ticks_n  = ticks_q;
		homing_n = homing_q;
		to_max_n = to_max_q;
		pulse    = 1'b0;
		started  = 1'b0;
		case (cmd.func)
			FUNC_TICK: begin
				ticks_n = ticks_inc;
				if (homing_q) begin
					// The limit level is looked at before any step.
					if (!cmd.limit_level) begin
						pos_n    = to_max_q ? cfg.bound_high : cfg.bound_low;
						homing_n = 1'b0;
					end else if (ticks_inc >= HOME_IV) begin
						pos_n   = pos_stepped;
						ticks_n = '0;
						pulse   = 1'b1;
					end
				end else if ((pos_q != tgt_q) && (ticks_inc >= cfg.step_interval)) begin
					pos_n   = pos_stepped;
					ticks_n = '0;
					pulse   = 1'b1;
				end
			end
			FUNC_HOME: begin
				homing_n = 1'b1;
				to_max_n = cmd.home_toward_max;
				dir_n    = cmd.home_toward_max;
			end
			FUNC_ABS: begin
				if (!homing_q) begin
					tgt_n = cmd.value;
					if (pos_q != cmd.value) begin
						dir_n   = $signed(pos_q) < $signed(cmd.value);
						started = 1'b1;
					end
				end
			end
			FUNC_REL: begin
				if (!homing_q && (cmd.value != '0)) begin
					dir_n   = ~cmd.value[DATA_W-1];
					tgt_n   = pos_q + cmd.value;
					started = 1'b1;
				end
			end
			FUNC_LOAD: begin
				if (!homing_q) begin
					pos_n = cmd.value;
					tgt_n = cmd.value;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tgt_q    <= '0;
			dir_q    <= 1'b0;
			ticks_q  <= '0;
			homing_q <= 1'b0;
			to_max_q <= 1'b0;
		end else if (advance) begin
			pos_q    <= pos_n;
			tgt_q    <= tgt_n;
			dir_q    <= dir_n;
			ticks_q  <= ticks_n;
			homing_q <= homing_n;
			to_max_q <= to_max_n;
		end
	end

	assign res.step_pulse   = pulse;
	assign res.dir_level    = dir_n;
	assign res.position_now = pos_n;
	assign res.at_target    = (pos_n == tgt_n);
	assign res.homing_busy  = homing_n;
	assign res.move_started = started;

endmodule

[hdl/stepper_step_generator.sv]
// A command word is accepted into the input register; its result enters the
// output register when the word advances. Throughput: one word per cycle
// unless the result side stalls; the state update is a single compare, count
// and add pass between the input register and the result register.
// Reset: arst_n clears both pipeline stages, the motion state and loads the
// registers with their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Stepper step generator
// Constant-speed step pulse generator with absolute and relative moves,
// position load and homing against a limit switch.
// ----------------------------------------------------------------------------
module stepper_step_generator
	import ssg_pkg::*;
#(
	parameter int unsigned HOME_INTERVAL = HOME_INTERVAL_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Command channel.
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  logic [2:0]               func,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     home_toward_max,
	input  logic                     limit_level,
	// Result channel.
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic                     step_pulse,
	output logic                     dir_level,
	output logic signed [DATA_W-1:0] position_now,
	output logic                     at_target,
	output logic                     homing_busy,
	output logic                     move_started,
	// Configuration port.
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	cfg_t cfg;
	cmd_t cmd_s1;
	res_t res_comb;
	res_t res_s2;
	logic valid_s1;
	logic valid_s2;
	logic advance;

	// The word in the input register moves on whenever the result register is
	// empty or is being emptied in the same cycle. The state is updated only
	// on that move, so a stalled result holds the state still as well.
	assign advance   = valid_s1 & (~valid_s2 | res_ready);
	// A new word may enter while the previous one is handed on.
	assign cmd_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	// The payload needs no reset; it is qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1.func            <= func;
			cmd_s1.value           <= value;
			cmd_s1.home_toward_max <= home_toward_max;
			cmd_s1.limit_level     <= limit_level;
		end
	end

	ssg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssg_core #(
		.HOME_INTERVAL (HOME_INTERVAL)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd     (cmd_s1),
		.cfg     (cfg),
		.res     (res_comb)
	);

	// Result register: filled on advance, emptied when the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid    = valid_s2;
	assign step_pulse   = res_s2.step_pulse;
	assign dir_level    = res_s2.dir_level;
	assign position_now = res_s2.position_now;
	assign at_target    = res_s2.at_target;
	assign homing_busy  = res_s2.homing_busy;
	assign move_started = res_s2.move_started;

endmodule

[hdl/ssg_checker.sv]
// ----------------------------------------------------------------------------
// Stepper step generator checker
// Port-level assertions on the result word and the flow control.
// ----------------------------------------------------------------------------
module ssg_checker
	import ssg_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cmd_ready,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic                     step_pulse,
	input logic signed [DATA_W-1:0] position_now,
	input logic                     at_target,
	input logic                     homing_busy,
	input logic                     move_started
);

	// Only ticks step and only moves start, so the two never meet.
	a_pulse_not_move: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && step_pulse |-> !move_started)
		else $error("step and move start in the same word");

	// A started move leaves the position off target and cannot occur in homing.
	a_move_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && move_started |-> !at_target && !homing_busy)
		else $error("move started while on target or homing");

	// A consumer that is ready always frees room for the next command.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> cmd_ready)
		else $error("command stalled although result side is ready");

	// A stalled result holds its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(position_now))
		else $error("result word changed while stalled");

endmodule

bind stepper_step_generator ssg_checker u_ssg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_ready    (cmd_ready),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.step_pulse   (step_pulse),
	.position_now (position_now),
	.at_target    (at_target),
	.homing_busy  (homing_busy),
	.move_started (move_started)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper step generator testbench
// Drives command words through the valid/ready channel and writes the
// configuration registers over the APB-style port between phases. Every result
// word is checked field by field, in order, against the result a directed row
// gives or else a predictor of the step generator that runs inside the bench.
// A directed table leads, then random phases under several register settings.
// ----------------------------------------------------------------------------
module tb;
	import ssg_pkg::*;

	// Function codes that the block must treat as no-operations.
	localparam logic [2:0] FUNC_SPARE5 = 3'd5;
	localparam logic [2:0] FUNC_SPARE6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE7 = 3'd7;
	// Register index with no register behind it; writes to it are dropped.
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam int unsigned PHASES         = 6;
	localparam int unsigned PHASE_WORDS    = 95;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned TABLE_ROWS     = 26;

	// One row of the directed table: a command word, how many times it is sent,
	// and, where it can be read off at a glance, the result it must give.
	typedef struct {
		cmd_t        word;
		int unsigned reps;
		bit          typed;
		res_t        want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic              cmd_valid;
	logic              cmd_ready;
	logic [2:0]        func;
	logic [DATA_W-1:0] value;
	logic              home_toward_max;
	logic              limit_level;

	logic              res_valid;
	logic              res_ready;
	logic              step_pulse;
	logic              dir_level;
	logic [DATA_W-1:0] position_now;
	logic              at_target;
	logic              homing_busy;
	logic              move_started;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Travels with the command word so that the monitor knows whether the
	// directed table gave a fixed result for it.
	bit   row_typed;
	res_t row_want;

	// Mirror of the block's motion state and registers.
	logic [DATA_W-1:0] pos_m;
	logic [DATA_W-1:0] target_m;
	logic              dir_m;
	logic [TICK_W-1:0] ticks_m;
	logic              homing_m;
	logic              home_max_m;
	logic [TICK_W-1:0] interval_m;
	logic [DATA_W-1:0] bound_low_m;
	logic [DATA_W-1:0] bound_high_m;

	res_t        status_due [$];
	int unsigned faults;
	int unsigned quiet_cycles;
	bit          calm;
	bit          hold_req;
	row_t        plan [TABLE_ROWS];

	stepper_step_generator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_ready       (cmd_ready),
		.func            (func),
		.value           (value),
		.home_toward_max (home_toward_max),
		.limit_level     (limit_level),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.step_pulse      (step_pulse),
		.dir_level       (dir_level),
		.position_now    (position_now),
		.at_target       (at_target),
		.homing_busy     (homing_busy),
		.move_started    (move_started),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the status word that one command word leaves behind, and moves
	// the mirrored state on. Ticks count up and saturate; a step is due when
	// the count reaches the interval (the fixed homing interval while homing).
	function automatic res_t next_status(cmd_t w);
		res_t r;
		logic pulse;
		logic started;
		pulse = 1'b0;
		started = 1'b0;
		case (w.func)
			FUNC_TICK: begin
				if (ticks_m != TICK_MAX)
					ticks_m = ticks_m + 1'b1;
				if (homing_m) begin
					// The limit switch is looked at before any homing step.
					if (!w.limit_level) begin
						pos_m = home_max_m ? bound_high_m : bound_low_m;
						homing_m = 1'b0;
					end else if (ticks_m >= HOME_INTERVAL_DEF) begin
						pos_m = dir_m ? pos_m + 1'b1 : pos_m - 1'b1;
						ticks_m = '0;
						pulse = 1'b1;
					end
				end else if (pos_m != target_m && ticks_m >= interval_m) begin
					pos_m = dir_m ? pos_m + 1'b1 : pos_m - 1'b1;
					ticks_m = '0;
					pulse = 1'b1;
				end
			end
			FUNC_HOME: begin
				homing_m = 1'b1;
				home_max_m = w.home_toward_max;
				dir_m = w.home_toward_max;
			end
			FUNC_ABS: begin
				if (!homing_m) begin
					target_m = w.value;
					if (pos_m != target_m) begin
						dir_m = $signed(pos_m) < $signed(target_m);
						started = 1'b1;
					end
				end
			end
			FUNC_REL: begin
				if (!homing_m && w.value != '0) begin
					dir_m = ~w.value[DATA_W-1];
					target_m = pos_m + w.value;
					started = 1'b1;
				end
			end
			FUNC_LOAD: begin
				if (!homing_m) begin
					pos_m = w.value;
					target_m = w.value;
				end
			end
			default: begin
			end
		endcase
		r.step_pulse = pulse;
		r.dir_level = dir_m;
		r.position_now = pos_m;
		r.at_target = pos_m == target_m;
		r.homing_busy = homing_m;
		r.move_started = started;
		return r;
	endfunction

	function automatic row_t cmd_row(logic [2:0] f, logic [DATA_W-1:0] v, logic to_max,
			logic lim, int unsigned n, bit typed, res_t want);
		row_t r;
		r.word.func = f;
		r.word.value = v;
		r.word.home_toward_max = to_max;
		r.word.limit_level = lim;
		r.reps = n;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic res_t status(logic pulse, logic dir, logic [DATA_W-1:0] pos,
			logic at, logic busy, logic started);
		res_t r;
		r.step_pulse = pulse;
		r.dir_level = dir;
		r.position_now = pos;
		r.at_target = at;
		r.homing_busy = busy;
		r.move_started = started;
		return r;
	endfunction

	// Mostly ticks with short moves around the present position, so that moves
	// finish and steps are seen; now and then a full-width value, a homing run
	// or a spare code. While homing, the limit switch is mostly not reached.
	function automatic cmd_t random_word();
		cmd_t w;
		int unsigned pick;
		logic [DATA_W-1:0] near;
		logic [DATA_W-1:0] nudge;
		w.value = $urandom;
		w.home_toward_max = 1'($urandom_range(1));
		w.limit_level = 1'($urandom_range(1));
		nudge = DATA_W'($urandom_range(12)) - DATA_W'(6);
		near = pos_m + nudge;
		pick = $urandom_range(99);
		if (homing_m) begin
			if (pick < 90) begin
				w.func = FUNC_TICK;
				w.limit_level = $urandom_range(119) != 0;
			end else if (pick < 94) begin
				w.func = (pick < 91) ? FUNC_ABS : ((pick < 92) ? FUNC_REL : FUNC_LOAD);
			end else begin
				w.func = FUNC_HOME;
			end
		end else if (pick < 78) begin
			w.func = FUNC_TICK;
		end else if (pick < 84) begin
			w.func = FUNC_ABS;
			if ($urandom_range(7) != 0)
				w.value = near;
		end else if (pick < 90) begin
			w.func = FUNC_REL;
			if ($urandom_range(7) != 0)
				w.value = nudge;
		end else if (pick < 93) begin
			w.func = FUNC_LOAD;
			if ($urandom_range(1) != 0)
				w.value = near;
		end else if (pick < 96) begin
			w.func = FUNC_HOME;
		end else begin
			w.func = (pick < 97) ? FUNC_SPARE5 : ((pick < 98) ? FUNC_SPARE6 : FUNC_SPARE7);
		end
		return w;
	endfunction

	// Offers one command word and returns at the falling edge after it has
	// been taken. Valid stays high between words unless a gap is drawn.
	task automatic send_word(input cmd_t w, input bit typed, input res_t want);
		if (!calm && $urandom_range(99) < 9) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		func <= w.func;
		value <= w.value;
		home_toward_max <= w.home_toward_max;
		limit_level <= w.limit_level;
		row_typed <= typed;
		row_want <= want;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
	endtask

	// Setup then access phase; the mirror takes the value at the access edge.
	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_STEP_INTERVAL:
				interval_m = (data[TICK_W-1:0] < MIN_INTERVAL) ? MIN_INTERVAL
				                                               : data[TICK_W-1:0];
			REG_BOUND_LOW:  bound_low_m = data;
			REG_BOUND_HIGH: bound_high_m = data;
			default: begin
			end
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// Lowers valid, waits until every expected word is back, and then lets the
	// two-stage pipeline drain.
	task automatic settle();
		cmd_valid <= 1'b0;
		while (status_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			faults++;
		end
	endtask

	// Receiver: random back-pressure, none while the bench is calm, and one
	// long hold-off on request so that the block fills up and stalls its input.
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				res_ready <= calm || ($urandom_range(99) >= 9);
			end
		end
	end

	// Monitor: predicts on every accepted command word, checks every accepted
	// result word against the oldest prediction, and watches for a hang.
	always @(posedge clk) begin : monitor
		res_t due;
		res_t got;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				got = next_status(cmd_t'({func, value, home_toward_max, limit_level}));
				status_due.push_back(row_typed ? row_want : got);
			end
			if (res_valid && res_ready) begin
				if (status_due.size() == 0) begin
					$error("result word with nothing expected");
					faults++;
				end else begin
					due = status_due.pop_front();
					check_field("step_pulse", DATA_W'(due.step_pulse),
						DATA_W'(step_pulse));
					check_field("dir_level", DATA_W'(due.dir_level),
						DATA_W'(dir_level));
					check_field("position_now", due.position_now, position_now);
					check_field("at_target", DATA_W'(due.at_target),
						DATA_W'(at_target));
					check_field("homing_busy", DATA_W'(due.homing_busy),
						DATA_W'(homing_busy));
					check_field("move_started", DATA_W'(due.move_started),
						DATA_W'(move_started));
				end
			end
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [DATA_W-1:0] ivl_word;
		logic [DATA_W-1:0] low_word;
		logic [DATA_W-1:0] high_word;

		arst_n = 1'b0;
		cmd_valid = 1'b0;
		func = FUNC_TICK;
		value = '0;
		home_toward_max = 1'b0;
		limit_level = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		row_typed = 1'b0;
		row_want = '0;
		faults = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;

		// Reset state of the mirror.
		pos_m = '0;
		target_m = '0;
		dir_m = 1'b0;
		ticks_m = '0;
		homing_m = 1'b0;
		home_max_m = 1'b0;
		interval_m = RST_INTERVAL;
		bound_low_m = RST_BOUND_LOW;
		bound_high_m = RST_BOUND_HIGH;

		// Directed table, run with the registers at their reset values. The
		// interval is 100 ticks, as is the homing interval.
		plan[0]  = cmd_row(FUNC_TICK, 32'h0000_0000, 0, 1, 1, 1,
			status(0, 0, 32'h0000_0000, 1, 0, 0));
		// Spare codes report the status and change nothing.
		plan[1]  = cmd_row(FUNC_SPARE5, 32'hFFFF_FFFF, 1, 0, 1, 1,
			status(0, 0, 32'h0000_0000, 1, 0, 0));
		plan[2]  = cmd_row(FUNC_SPARE7, 32'h5555_AAAA, 0, 1, 1, 1,
			status(0, 0, 32'h0000_0000, 1, 0, 0));
		// A move to where the motor already stands, and a relative move of zero.
		plan[3]  = cmd_row(FUNC_ABS, 32'h0000_0000, 0, 1, 1, 1,
			status(0, 0, 32'h0000_0000, 1, 0, 0));
		plan[4]  = cmd_row(FUNC_REL, 32'h0000_0000, 1, 0, 1, 1,
			status(0, 0, 32'h0000_0000, 1, 0, 0));
		// One step up from the largest position wraps to the smallest.
		plan[5]  = cmd_row(FUNC_LOAD, 32'h7FFF_FFFF, 0, 1, 1, 1,
			status(0, 0, 32'h7FFF_FFFF, 1, 0, 0));
		plan[6]  = cmd_row(FUNC_REL, 32'h0000_0001, 0, 1, 1, 1,
			status(0, 1, 32'h7FFF_FFFF, 0, 0, 1));
		plan[7]  = cmd_row(FUNC_TICK, 32'h0000_0000, 0, 1, 98, 0, '0);
		plan[8]  = cmd_row(FUNC_TICK, 32'h0000_0000, 0, 1, 1, 1,
			status(1, 1, 32'h8000_0000, 1, 0, 0));
		plan[9]  = cmd_row(FUNC_ABS, 32'h8000_0000, 0, 1, 1, 1,
			status(0, 1, 32'h8000_0000, 1, 0, 0));
		// And one step down wraps back again.
		plan[10] = cmd_row(FUNC_REL, 32'hFFFF_FFFF, 0, 1, 1, 1,
			status(0, 0, 32'h8000_0000, 0, 0, 1));
		plan[11] = cmd_row(FUNC_TICK, 32'h0000_0000, 1, 1, 100, 0, '0);
		plan[12] = cmd_row(FUNC_ABS, 32'h8000_0000, 0, 1, 1, 1,
			status(0, 0, 32'h7FFF_FFFF, 0, 0, 1));
		// Homing: moves and loads are ignored while it runs, a new homing
		// command turns it round, and a low limit ends it on the bound.
		plan[13] = cmd_row(FUNC_HOME, 32'h0000_0000, 0, 1, 1, 1,
			status(0, 0, 32'h7FFF_FFFF, 0, 1, 0));
		plan[14] = cmd_row(FUNC_ABS, 32'h0000_0005, 0, 1, 1, 1,
			status(0, 0, 32'h7FFF_FFFF, 0, 1, 0));
		plan[15] = cmd_row(FUNC_REL, 32'h0000_0005, 0, 1, 1, 1,
			status(0, 0, 32'h7FFF_FFFF, 0, 1, 0));
		plan[16] = cmd_row(FUNC_LOAD, 32'h0000_0005, 0, 1, 1, 1,
			status(0, 0, 32'h7FFF_FFFF, 0, 1, 0));
		plan[17] = cmd_row(FUNC_TICK, 32'h0000_0000, 0, 1, 100, 0, '0);
		plan[18] = cmd_row(FUNC_HOME, 32'h0000_0000, 1, 1, 1, 0, '0);
		plan[19] = cmd_row(FUNC_TICK, 32'h0000_0000, 0, 0, 1, 1,
			status(0, 1, 32'h7FFF_FFFF, 0, 0, 0));
		plan[20] = cmd_row(FUNC_HOME, 32'h0000_0000, 0, 1, 1, 0, '0);
		plan[21] = cmd_row(FUNC_TICK, 32'h0000_0000, 1, 0, 1, 1,
			status(0, 0, 32'h0000_0000, 0, 0, 0));
		// The tick count keeps running while the motor stands on target, so
		// after a long idle run the first tick of the next move steps at once.
		plan[22] = cmd_row(FUNC_LOAD, 32'hFFFF_FFFF, 0, 1, 1, 1,
			status(0, 0, 32'hFFFF_FFFF, 1, 0, 0));
		plan[23] = cmd_row(FUNC_TICK, 32'h0000_0000, 0, 1, 120, 0, '0);
		plan[24] = cmd_row(FUNC_REL, 32'h0000_0002, 0, 1, 1, 1,
			status(0, 1, 32'hFFFF_FFFF, 0, 0, 1));
		plan[25] = cmd_row(FUNC_TICK, 32'h0000_0000, 0, 1, 1, 1,
			status(1, 1, 32'h0000_0000, 0, 0, 0));

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			repeat (plan[i].reps) send_word(plan[i].word, plan[i].typed, plan[i].want);
		settle();

		// Random phases, each under its own register setting. The interval words of
		// the first two phases carry random upper bits that the register must drop.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					ivl_word = {16'($urandom_range(16'hFFFF)), 16'd0};
					low_word = 32'h8000_0000;
					high_word = 32'h7FFF_FFFF;
				end
				1: begin
					ivl_word = {16'($urandom_range(16'hFFFF)), 16'hFFFF};
					low_word = $urandom;
					high_word = $urandom;
				end
				2: begin
					ivl_word = 32'd39;
					low_word = 32'hFFFF_FFFF;
					high_word = 32'h0000_0000;
				end
				3: begin
					ivl_word = 32'd41;
					low_word = 32'h0000_0001;
					high_word = 32'h8000_0000;
				end
				4: begin
					ivl_word = 32'd100;
					low_word = $urandom;
					high_word = $urandom;
				end
				default: begin
					ivl_word = $urandom_range(300, 40);
					low_word = 32'h0000_0000;
					high_word = 32'h7FFF_FFFF;
				end
			endcase
			reg_write(REG_STEP_INTERVAL, ivl_word);
			reg_write(REG_BOUND_LOW, low_word);
			reg_write(REG_BOUND_HIGH, high_word);
			// The unmapped index must leave every register as it is.
			if (p == 0)
				reg_write(REG_SPARE, 32'hFFFF_FFFF);
			// The second phase opens with the long hold-off on the result side;
			// the fourth runs with no gaps on either side.
			hold_req = p == 1;
			calm = p == 3;
			repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
			settle();
		end

		if (faults == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

[stepper_step_generator.f]
hdl/ssg_pkg.sv
hdl/ssg_regs.sv
hdl/ssg_core.sv
hdl/stepper_step_generator.sv
hdl/ssg_checker.sv
tb/sv/tb.sv
